// ===== rtl/sha1_byte_stream_hasher_top_defines.svh =====
// Assertion macros shared by the hasher RTL.
`ifndef SHA1_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA1_BYTE_STREAM_HASHER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SHA1BS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHA1BS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sha1bs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sha1bs_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int DIGEST_WORDS = 5;
    localparam logic [2:0] LAST_IDX = 3'(DIGEST_WORDS - 1);

    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [6:0] LAST_ROUND = 7'd79;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // queued item passed from front to back end
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       has_byte;
    } item_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADDC  = 5'b01000,
        ST_OUT   = 5'b10000
    } core_state_t;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        return {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        return {x[1:0], x[31:2]};
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] r;
        if (t < 7'd20) begin
            r = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            r = b ^ c ^ d;
        end else if (t < 7'd60) begin
            r = (b & c) | (b & d) | (c & d);
        end else begin
            r = b ^ c ^ d;
        end
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] r;
        if (t < 7'd20) begin
            r = K0;
        end else if (t < 7'd40) begin
            r = K1;
        end else if (t < 7'd60) begin
            r = K2;
        end else begin
            r = K3;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sha1bs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sha1_byte_stream_hasher_top_defines.svh"
module sha1bs_front
    import sha1bs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_message_byte,
    input  wire logic       s_final_flag,
    input  wire logic       s_no_byte,
    output logic            q_valid,
    input  wire logic       q_ready,
    output item_t           q_item
);

    item_t           slot_reg [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]  count_reg, count_next;
    logic            accept, keep, push, pop;

    assign s_ready = (count_reg != QCW'(QDEPTH));
    assign accept  = s_valid && s_ready;
    // an item with no byte that does not end the message changes nothing: drop it
    assign keep    = !s_no_byte || s_final_flag;
    assign push    = accept && keep;
    assign q_valid = (count_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCW'(1);
        end else if (!push && pop) begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= '{data: s_message_byte, fin: s_final_flag,
                                      has_byte: !s_no_byte};
        end
    end

    `SHA1BS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= QCW'(QDEPTH), "queue overfilled")
    `SHA1BS_ASSERT_NXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + QCW'(1), "push lost")
    `SHA1BS_ASSERT_NXT(a_pop_shrinks, pop && !push, count_reg == $past(count_reg) - QCW'(1), "pop lost")

endmodule
`default_nettype wire

// ===== rtl/sha1bs_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sha1_byte_stream_hasher_top_defines.svh"
module sha1bs_core
    import sha1bs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire item_t       q_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word
);

    core_state_t  state_reg, state_next;
    logic [31:0]  chain_reg [DIGEST_WORDS];
    logic [31:0]  chain_next [DIGEST_WORDS];
    logic [31:0]  w_reg [16];
    logic [31:0]  w_next [16];
    logic [23:0]  acc_reg, acc_next;
    logic [31:0]  va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    logic [31:0]  va_next, vb_next, vc_next, vd_next, ve_next;
    logic [6:0]   round_reg, round_next;
    logic [5:0]   pos_reg, pos_next;
    logic [60:0]  count_reg, count_next;
    logic [63:0]  len_reg, len_next;
    logic [2:0]   idx_reg, idx_next;
    logic         fin_pend_reg, fin_pend_next;
    logic         sent80_reg, sent80_next;
    logic         len_phase_reg, len_phase_next;
    logic         len_done_reg, len_done_next;
    logic         place_en;
    logic [7:0]   place_byte;
    logic [31:0]  t_sum;
    logic         last_hs;

    assign q_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_digest_word = chain_reg[idx_reg];
    assign m_word_index  = idx_reg;
    assign m_last_word   = (idx_reg == LAST_IDX);
    assign last_hs       = m_valid && m_ready && (idx_reg == LAST_IDX);

    assign t_sum = rotl5(va_reg) + round_f(round_reg, vb_reg, vc_reg, vd_reg)
                   + ve_reg + round_k(round_reg) + w_reg[0];

    always_comb begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        w_next         = w_reg;
        acc_next       = acc_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        vc_next        = vc_reg;
        vd_next        = vd_reg;
        ve_next        = ve_reg;
        round_next     = round_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        fin_pend_next  = fin_pend_reg;
        sent80_next    = sent80_reg;
        len_phase_next = len_phase_reg;
        len_done_next  = len_done_reg;
        place_en       = 1'b0;
        place_byte     = 8'h00;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    fin_pend_next = q_item.fin;
                    if (q_item.has_byte) begin
                        place_en   = 1'b1;
                        place_byte = q_item.data;
                        count_next = count_reg + 61'd1;
                        if (pos_reg == LAST_POS) begin
                            state_next = ST_ROUND;
                            round_next = '0;
                            va_next    = chain_reg[0];
                            vb_next    = chain_reg[1];
                            vc_next    = chain_reg[2];
                            vd_next    = chain_reg[3];
                            ve_next    = chain_reg[4];
                        end else if (q_item.fin) begin
                            state_next = ST_PAD;
                        end
                    end else begin
                        // only final items reach here without a byte
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                place_en = 1'b1;
                if (!sent80_reg) begin
                    place_byte  = PAD_BYTE;
                    sent80_next = 1'b1;
                    len_next    = {count_reg, 3'b000};
                    if (pos_reg < LEN_POS) begin
                        len_phase_next = 1'b1;
                    end
                end else if (len_phase_reg && pos_reg >= LEN_POS) begin
                    place_byte = len_reg[63:56];
                    len_next   = {len_reg[55:0], 8'h00};
                end
                if (pos_reg == LAST_POS) begin
                    state_next     = ST_ROUND;
                    round_next     = '0;
                    va_next        = chain_reg[0];
                    vb_next        = chain_reg[1];
                    vc_next        = chain_reg[2];
                    vd_next        = chain_reg[3];
                    ve_next        = chain_reg[4];
                    len_done_next  = len_phase_reg;
                    len_phase_next = 1'b1;
                end
            end
            ST_ROUND: begin
                va_next = t_sum;
                vb_next = va_reg;
                vc_next = rotl30(vb_reg);
                vd_next = vc_reg;
                ve_next = vd_reg;
                for (int i = 0; i < 15; i++) begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[15] = rotl1(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]);
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_ADDC;
                end else begin
                    round_next = round_reg + 7'd1;
                end
            end
            ST_ADDC: begin
                chain_next[0] = chain_reg[0] + va_reg;
                chain_next[1] = chain_reg[1] + vb_reg;
                chain_next[2] = chain_reg[2] + vc_reg;
                chain_next[3] = chain_reg[3] + vd_reg;
                chain_next[4] = chain_reg[4] + ve_reg;
                idx_next      = '0;
                if (!fin_pend_reg) begin
                    state_next = ST_IDLE;
                end else if (len_done_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (idx_reg == LAST_IDX) begin
                        // digest gone: start the next message afresh
                        state_next     = ST_IDLE;
                        chain_next     = H_INIT;
                        count_next     = '0;
                        pos_next       = '0;
                        fin_pend_next  = 1'b0;
                        sent80_next    = 1'b0;
                        len_phase_next = 1'b0;
                        len_done_next  = 1'b0;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // byte packing: three bytes held, the fourth completes a word
        if (place_en) begin
            acc_next = {acc_reg[15:0], place_byte};
            pos_next = pos_reg + 6'd1;
            if (pos_reg[1:0] == 2'b11) begin
                for (int i = 0; i < 15; i++) begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[15] = {acc_reg, place_byte};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chain_reg     <= H_INIT;
            pos_reg       <= '0;
            count_reg     <= '0;
            round_reg     <= '0;
            idx_reg       <= '0;
            fin_pend_reg  <= 1'b0;
            sent80_reg    <= 1'b0;
            len_phase_reg <= 1'b0;
            len_done_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            fin_pend_reg  <= fin_pend_next;
            sent80_reg    <= sent80_next;
            len_phase_reg <= len_phase_next;
            len_done_reg  <= len_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg   <= w_next;
        acc_reg <= acc_next;
        va_reg  <= va_next;
        vb_reg  <= vb_next;
        vc_reg  <= vc_next;
        vd_reg  <= vd_next;
        ve_reg  <= ve_next;
        len_reg <= len_next;
    end

    `SHA1BS_ASSERT_IMP(a_round_range, state_reg == ST_ROUND, round_reg <= LAST_ROUND, "round overrun")
    `SHA1BS_ASSERT_NXT(a_round_end, state_reg == ST_ROUND && round_reg == LAST_ROUND, state_reg == ST_ADDC, "missed chain add")
    `SHA1BS_ASSERT_NXT(a_restart, last_hs, state_reg == ST_IDLE && pos_reg == '0 && count_reg == '0, "no restart after digest")
    `SHA1BS_ASSERT_IMP(a_out_excl, q_ready, !m_valid, "pop during digest output")

endmodule
`default_nettype wire

// ===== rtl/sha1_byte_stream_hasher_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// SHA-1 hasher fed one message byte per item.
// Input channel s_*: s_message_byte, s_final_flag, s_no_byte under s_valid/s_ready.
//   An item with s_no_byte set and s_final_flag clear is taken and dropped.
//   s_final_flag ends the message; with s_no_byte set it ends it as it stands
//   (empty message, or one ending on a 64-byte boundary).
// Result channel m_*: five items per message, m_digest_word H0..H4 with
//   m_word_index 0..4, m_last_word on the fifth.
// A four-item queue sits in front of the hashing engine, so input is taken
// while the engine compresses or while a digest waits on m_ready.
// In the engine, every 64th byte is followed by 80 rounds at one per cycle
//   through the single round unit, then the chain add; the engine takes no
//   queued byte meanwhile.
// Final item: padding runs one byte a cycle to the block end, or over two
//   blocks when the length field does not fit, each padded block then taking
//   the rounds and the chain add; then one digest word per accepted cycle.
// Receiver stall: the digest words hold until taken; the engine waits and the
//   queue fills, then s_ready falls.
// Reset (aresetn low, synchronous) empties the queue, restores H0..H4 and
//   clears the byte count; no clearing pass is needed.
module sha1_byte_stream_hasher_top
    import sha1bs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_message_byte,
    input  wire logic        s_final_flag,
    input  wire logic        s_no_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word
);

    // queue to engine
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    sha1bs_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_byte (s_message_byte),
        .s_final_flag   (s_final_flag),
        .s_no_byte      (s_no_byte),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_item         (q_item)
    );

    sha1bs_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

endmodule
`default_nettype wire

// ===== sim/sha1_byte_stream_hasher_top_tb.sv =====
`timescale 1ns / 1ps
module sha1_byte_stream_hasher_top_tb;

    // Longest run of cycles with no item moving on either channel before the
    // run is called hung. The limit sits well above the slowest correct stretch:
    // a final item needing two padded blocks behind a full queue, with the
    // receiver stalling on every word.
    localparam int HANG_LIMIT   = 5000;
    localparam int ITEM_TARGET  = 430;
    // no idling on either side once this many items have gone in
    localparam int CALM_FROM    = 370;
    // cycles allowed after the last digest word for anything stray to show
    localparam int DRAIN_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_message_byte;
    logic        s_final_flag;
    logic        s_no_byte;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        is_last;
    } digest_word_t;

    // SHA-1 engine of its own: tracks chaining value, block buffer and byte
    // count per accepted item, and queues the five digest words due on a
    // final item.
    class sha1_digest_tracker;
        logic [31:0]  chain [5];
        logic [31:0]  blk [16];
        logic [60:0]  byte_count;
        digest_word_t digest_due [$];
        int           failures;

        function new();
            failures = 0;
            restart();
            for (int i = 0; i < 16; i++) blk[i] = '0;
        endfunction

        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hEFCDAB89;
            chain[2] = 32'h98BADCFE;
            chain[3] = 32'h10325476;
            chain[4] = 32'hC3D2E1F0;
            byte_count = '0;
        endfunction

        function int pending();
            return digest_due.size();
        endfunction

        // big-endian placement; first byte of a word clears the word
        function void put_byte(int unsigned pos, logic [7:0] b);
            int unsigned w;
            int unsigned sh;
            w = pos / 4;
            sh = (3 - (pos % 4)) * 8;
            if (pos % 4 == 0) blk[w] = '0;
            blk[w] = blk[w] | ({24'd0, b} << sh);
        endfunction

        function void run_rounds();
            logic [31:0] sched [80];
            logic [31:0] a, b, c, d, e, f, k, x, nxt;
            for (int t = 0; t < 16; t++) sched[t] = blk[t];
            for (int t = 16; t < 80; t++) begin
                x = sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16];
                sched[t] = {x[30:0], x[31]};
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int t = 0; t < 80; t++) begin
                if (t < 20) begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end else if (t < 40) begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end else if (t < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end else begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                nxt = {a[26:0], a[31:27]} + f + e + k + sched[t];
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = nxt;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        function void take_item(logic [7:0] b, logic fin, logic nb);
            int unsigned pos;
            logic [63:0] bit_len;
            digest_word_t dw;
            if (!nb) begin
                pos = byte_count[5:0];
                put_byte(pos, b);
                byte_count = byte_count + 61'd1;
                if (pos == 63) run_rounds();
            end
            if (!fin) return;
            pos = byte_count[5:0];
            bit_len = {byte_count, 3'b000};
            put_byte(pos, 8'h80);
            for (int w = pos / 4 + 1; w < 16; w++) blk[w] = '0;
            // no room for the length field: close this block, start a blank one
            if (pos >= 56) begin
                run_rounds();
                for (int w = 0; w < 14; w++) blk[w] = '0;
            end
            blk[14] = bit_len[63:32];
            blk[15] = bit_len[31:0];
            run_rounds();
            for (int i = 0; i < 5; i++) begin
                dw.word = chain[i];
                dw.idx = 3'(i);
                dw.is_last = (i == 4);
                digest_due.push_back(dw);
            end
            restart();
        endfunction

        function void check_word(logic [31:0] word, logic [2:0] idx, logic is_last);
            digest_word_t dw;
            if (digest_due.size() == 0) begin
                $display("%0t: digest word %08h idx %0d with none expected", $time, word, idx);
                failures++;
                return;
            end
            dw = digest_due.pop_front();
            if (word !== dw.word) begin
                $display("%0t: digest_word expected %08h actual %08h", $time, dw.word, word);
                failures++;
            end
            if (idx !== dw.idx) begin
                $display("%0t: word_index expected %0d actual %0d", $time, dw.idx, idx);
                failures++;
            end
            if (is_last !== dw.is_last) begin
                $display("%0t: last_word expected %0b actual %0b", $time, dw.is_last, is_last);
                failures++;
            end
        endfunction
    endclass

    sha1_digest_tracker board = new();

    int items_sent = 0;
    bit calm = 1'b0;
    int idle_run = 0;

    sha1_byte_stream_hasher_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_byte (s_message_byte),
        .s_final_flag   (s_final_flag),
        .s_no_byte      (s_no_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digest_word  (m_digest_word),
        .m_word_index   (m_word_index),
        .m_last_word    (m_last_word)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Both monitors sample at the edge, so they see the values the block saw.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.take_item(s_message_byte, s_final_flag, s_no_byte);
        end
        if (aresetn && m_valid && m_ready) begin
            board.check_word(m_digest_word, m_word_index, m_last_word);
        end
    end

    // Hang detection: counts edges at which no item moves on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_run <= 0;
            end else if (idle_run >= HANG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, HANG_LIMIT);
                $display("status: fail");
                $finish;
            end else begin
                idle_run <= idle_run + 1;
            end
        end
    end

    // Receiver: random stall bursts between runs of ready,
    // always ready once the run has gone calm.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // One item on the input channel. Valid is left high after acceptance so
    // that back-to-back items never lower and raise it within one edge; any
    // pause lowers it first.
    task automatic send_item(input logic [7:0] b, input logic fin, input logic nb);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_message_byte <= b;
        s_final_flag <= fin;
        s_no_byte <= nb;
        do @(posedge aclk); while (!s_ready);
        // dropped items do not count towards the stimulus total
        if (fin || !nb) items_sent++;
        if (items_sent >= CALM_FROM) calm = 1'b1;
    endtask

    // A whole message of random bytes. The final flag rides either on the
    // last byte or on a closing item with no byte; the latter is the only
    // way to end an empty message.
    // Now and then an ignored no-byte item is slipped in as noise.
    task automatic send_message(input int len);
        bit tail_on_byte;
        tail_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b1);
            send_item(8'($urandom), tail_on_byte && (i == len - 1), 1'b0);
        end
        if (!tail_on_byte) send_item(8'($urandom), 1'b1, 1'b1);
    endtask

    initial begin
        int len;
        s_valid <= 1'b0;
        s_message_byte <= '0;
        s_final_flag <= 1'b0;
        s_no_byte <= 1'b0;
        aresetn <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        // empty message: final item with no byte straight after reset
        send_item(8'h00, 1'b1, 1'b1);
        // "abc", final flag carried by the last byte
        send_item(8'h61, 1'b0, 1'b0);
        send_item(8'h62, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        // "abc" again, with an ignored item (all-ones payload) mid-message
        // and the message closed by a final item with no byte
        send_item(8'h61, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h62, 1'b0, 1'b0);
        send_item(8'h63, 1'b0, 1'b0);
        send_item(8'h5A, 1'b1, 1'b1);
        // one-byte messages at the byte extremes
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        // empty message whose ignored payload is all ones
        send_item(8'hFF, 1'b1, 1'b1);
        // ignored item between messages must not disturb the next one
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h80, 1'b0, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);

        // Sender holds off until every digest word due has been taken.
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);

        // Random part: many short messages, plenty that land on or next to
        // the padding boundaries (55/56 bytes left, whole blocks), some longer.
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(0, 12);
                4, 5, 6: begin
                    case ($urandom_range(0, 7))
                        0: len = 55;
                        1: len = 56;
                        2: len = 57;
                        3: len = 63;
                        4: len = 64;
                        5: len = 65;
                        6: len = 119;
                        default: len = 128;
                    endcase
                end
                default: len = $urandom_range(0, 140);
            endcase
            // keep the total near the target
            if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
            send_message(len);
        end

        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sha1_byte_stream_hasher_top.f =====
+incdir+rtl
rtl/sha1bs_pkg.sv
rtl/sha1bs_front.sv
rtl/sha1bs_core.sv
rtl/sha1_byte_stream_hasher_top.sv
sim/sha1_byte_stream_hasher_top_tb.sv
